@@ hdl/ita_pkg.sv @@
`timescale 1ns / 1ps

package ita_pkg;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int RADIX_W = 6;
    localparam int FIELD_W = 6;
    localparam int FLAGS_W = 7;
    localparam int CHAR_W  = 8;

    // Default sizing
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DEF_MAX_FIELD  = 62;
    localparam int MAX_PRECISION  = 60;

    // Valid radix range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    // Divider: quotient bits retired per cycle
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = DATA_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

    // Format flag bit positions
    localparam int FLAG_ZEROPAD = 0;
    localparam int FLAG_SIGNED  = 1;
    localparam int FLAG_PLUS    = 2;
    localparam int FLAG_SPACE   = 3;
    localparam int FLAG_LEFT    = 4;
    localparam int FLAG_PREFIX  = 5;
    localparam int FLAG_LOWER   = 6;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    // Digit value to ASCII, 0-9 then letters
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [RADIX_W-1:0] d,
        input logic               lower
    );
        logic [CHAR_W-1:0] d8;
        d8 = CHAR_W'(d);
        if (d8 < 8'd10)
        begin
            return CH_ZERO + d8;
        end
        return (lower ? CH_LO_A : CH_UP_A) + d8 - 8'd10;
    endfunction

endpackage

@@ hdl/ita_ram.sv @@
`timescale 1ns / 1ps

module ita_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ita_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, BITS_PER_STEP quotient bits per cycle.
module ita_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [ita_pkg::DATA_W-1:0]  dividend,
    input  logic [ita_pkg::RADIX_W-1:0] divisor,
    output logic                        done,
    output logic [ita_pkg::DATA_W-1:0]  quotient,
    output logic [ita_pkg::RADIX_W-1:0] remainder
);

    import ita_pkg::*;

    logic                  run_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [DATA_W-1:0]     work_reg;
    logic [RADIX_W:0]      rem_reg;
    logic [RADIX_W-1:0]    dvs_reg;

    logic [DATA_W-1:0]     work_next;
    logic [RADIX_W:0]      rem_next;

    // One step: shift in dividend bits, subtract where it fits
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            rem_next  = {rem_next[RADIX_W-1:0], work_next[DATA_W-1]};
            work_next = {work_next[DATA_W-2:0], 1'b0};
            if (rem_next >= {1'b0, dvs_reg})
            begin
                rem_next     = rem_next - {1'b0, dvs_reg};
                work_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg[RADIX_W-1:0];

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps

// printf-style integer formatter. Pulse start while busy is low to hand over
// one value with its radix (2..36), field width, minimum digit count and flags.
// The text comes back one character per strobe cycle: leading spaces, sign,
// octal "0" or hex "0x"/"0X" prefix, zero padding, digits, trailing spaces;
// last_char marks the final character. There is no backpressure: each result
// is valid for exactly one cycle and must be captured then. A radix outside
// 2..36 returns a single strobe with bad_radix and last_char set and out_char
// zero in the cycle after start, and never raises busy.
// Timing: digits come from a restoring divider that retires 4 quotient
// bits per cycle, one division per digit. Within a text segment characters
// stream at one per cycle; strobe may stay low between one segment and
// the next.

module integer_to_ascii_formatter #(
    parameter int MAX_DIGITS = ita_pkg::DEF_MAX_DIGITS,
    parameter int MAX_FIELD  = ita_pkg::DEF_MAX_FIELD
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ita_pkg::DATA_W-1:0]  value,
    input  logic [ita_pkg::RADIX_W-1:0] radix,
    input  logic [ita_pkg::FIELD_W-1:0] text_width,
    input  logic [ita_pkg::FIELD_W-1:0] min_digits,
    input  logic [ita_pkg::FLAGS_W-1:0] format_flags,
    output logic                        strobe,
    output logic [ita_pkg::CHAR_W-1:0]  out_char,
    output logic                        last_char,
    output logic                        bad_radix
);

    import ita_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int SIZE_W = 8;

    // Sequencer: divide, plan the padding, then walk the text segments
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DIVIDE = 10'b00_0000_0010,
        ST_PLAN   = 10'b00_0000_0100,
        ST_LEAD   = 10'b00_0000_1000,
        ST_SIGN   = 10'b00_0001_0000,
        ST_PFX    = 10'b00_0010_0000,
        ST_MID    = 10'b00_0100_0000,
        ST_ZERO   = 10'b00_1000_0000,
        ST_DIGIT  = 10'b01_0000_0000,
        ST_TRAIL  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Output register
    logic               strobe_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               last_reg;
    logic               bad_reg;

    // Per-transaction context
    logic [FIELD_W-1:0] width_reg,    width_next;
    logic [FIELD_W-1:0] prec_reg,     prec_next;
    logic               lead_reg,     lead_next;     // space pad before sign
    logic               zp_reg,       zp_next;       // zero pad after prefix
    logic               lower_reg,    lower_next;
    logic               hex_reg,      hex_next;
    logic               has_sign_reg, has_sign_next;
    logic [CHAR_W-1:0]  sign_reg,     sign_next;
    logic [1:0]         pfx_len_reg,  pfx_len_next;
    logic [RADIX_W-1:0] radix_hold_reg, radix_hold_next;

    // Counters
    logic [CNT_W-1:0]   ndig_reg,     ndig_next;
    logic [IDX_W-1:0]   dig_idx_reg,  dig_idx_next;
    logic [FIELD_W-1:0] pad_reg,      pad_next;
    logic [FIELD_W-1:0] zcnt_reg,     zcnt_next;
    logic [1:0]         pfx_cnt_reg,  pfx_cnt_next;

    // Divider and digit store
    logic               div_go;
    logic [DATA_W-1:0]  div_dividend;
    logic               div_done;
    logic [DATA_W-1:0]  div_quot;
    logic [RADIX_W-1:0] div_rem;
    logic [RADIX_W-1:0] div_radix;
    logic               ram_we;
    logic [RADIX_W-1:0] ram_rdata;

    // Emission
    logic               emit;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;
    logic               emit_bad;

    // Decode of the incoming transaction
    logic               radix_ok;
    logic               neg_in;
    logic [DATA_W-1:0]  mag_in;
    logic               prefix_in;

    // Padding plan
    logic [SIZE_W-1:0]  ndig8;
    logic [SIZE_W-1:0]  prec8;
    logic [SIZE_W-1:0]  precp8;
    logic [SIZE_W-1:0]  size8;

    assign radix_ok  = radix inside {[RADIX_MIN:RADIX_MAX]};
    assign neg_in    = format_flags[FLAG_SIGNED] && value[DATA_W-1];
    assign mag_in    = neg_in ? (DATA_W'(0) - value) : value;
    assign prefix_in = format_flags[FLAG_PREFIX];

    // size = width - sign - prefix - max(prec, digits); negative means no pad
    assign ndig8  = SIZE_W'(ndig_reg);
    assign prec8  = SIZE_W'(prec_reg);
    assign precp8 = (ndig8 > prec8) ? ndig8 : prec8;
    assign size8  = SIZE_W'(width_reg) - SIZE_W'(has_sign_reg) - SIZE_W'(pfx_len_reg)
                    - precp8;

    // Radix for the divider: live input on the start cycle, held afterwards
    assign div_radix = (state_reg == ST_IDLE) ? radix : radix_hold_reg;

    ita_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_dividend),
        .divisor   (div_radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ita_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ndig_reg[IDX_W-1:0]),
        .wdata (div_rem),
        .raddr (dig_idx_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        prec_next       = prec_reg;
        lead_next       = lead_reg;
        zp_next         = zp_reg;
        lower_next      = lower_reg;
        hex_next        = hex_reg;
        has_sign_next   = has_sign_reg;
        sign_next       = sign_reg;
        pfx_len_next    = pfx_len_reg;
        radix_hold_next = radix_hold_reg;
        ndig_next       = ndig_reg;
        dig_idx_next    = dig_idx_reg;
        pad_next        = pad_reg;
        zcnt_next       = zcnt_reg;
        pfx_cnt_next    = pfx_cnt_reg;
        div_go          = 1'b0;
        div_dividend    = div_quot;
        ram_we          = 1'b0;
        emit            = 1'b0;
        emit_char       = CH_NUL;
        emit_last       = 1'b0;
        emit_bad        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!radix_ok)
                    begin
                        // Error transaction: one result, no text
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_bad  = 1'b1;
                    end
                    else
                    begin
                        width_next = (text_width > FIELD_W'(MAX_FIELD)) ?
                                     FIELD_W'(MAX_FIELD) : text_width;
                        prec_next  = (min_digits > FIELD_W'(MAX_PRECISION)) ?
                                     FIELD_W'(MAX_PRECISION) : min_digits;
                        // Left justify cancels zero padding
                        zp_next    = format_flags[FLAG_ZEROPAD] && !format_flags[FLAG_LEFT];
                        lead_next  = !format_flags[FLAG_ZEROPAD] && !format_flags[FLAG_LEFT];
                        lower_next = format_flags[FLAG_LOWER];
                        hex_next   = (radix == RADIX_HEX);
                        radix_hold_next = radix;
                        if (neg_in)
                        begin
                            has_sign_next = 1'b1;
                            sign_next     = CH_MINUS;
                        end
                        else if (format_flags[FLAG_PLUS])
                        begin
                            has_sign_next = 1'b1;
                            sign_next     = CH_PLUS;
                        end
                        else if (format_flags[FLAG_SPACE])
                        begin
                            has_sign_next = 1'b1;
                            sign_next     = CH_SPACE;
                        end
                        else
                        begin
                            has_sign_next = 1'b0;
                            sign_next     = CH_NUL;
                        end
                        if (prefix_in && radix == RADIX_HEX)
                        begin
                            pfx_len_next = 2'd2;
                        end
                        else if (prefix_in && radix == RADIX_OCT)
                        begin
                            pfx_len_next = 2'd1;
                        end
                        else
                        begin
                            pfx_len_next = 2'd0;
                        end
                        ndig_next    = '0;
                        div_go       = 1'b1;
                        div_dividend = mag_in;
                        state_next   = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    // Store remainder, least significant digit first
                    ram_we    = 1'b1;
                    ndig_next = ndig_reg + 1'b1;
                    if (div_quot == '0 || ndig_reg == CNT_W'(MAX_DIGITS - 1))
                    begin
                        state_next = ST_PLAN;
                    end
                    else
                    begin
                        div_go = 1'b1;
                    end
                end
            end

            ST_PLAN:
            begin
                pad_next     = size8[SIZE_W-1] ? '0 : size8[FIELD_W-1:0];
                zcnt_next    = FIELD_W'(precp8 - ndig8);
                dig_idx_next = IDX_W'(ndig_reg - 1'b1);
                pfx_cnt_next = pfx_len_reg;
                state_next   = ST_LEAD;
            end

            ST_LEAD:
            begin
                if (lead_reg && pad_reg != '0)
                begin
                    emit      = 1'b1;
                    emit_char = CH_SPACE;
                    pad_next  = pad_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end

            ST_SIGN:
            begin
                emit       = has_sign_reg;
                emit_char  = sign_reg;
                state_next = ST_PFX;
            end

            ST_PFX:
            begin
                if (pfx_cnt_reg != 2'd0)
                begin
                    emit         = 1'b1;
                    emit_char    = CH_ZERO;
                    if (pfx_cnt_reg == 2'd1 && hex_reg)
                    begin
                        emit_char = lower_reg ? CH_LO_X : CH_UP_X;
                    end
                    pfx_cnt_next = pfx_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_MID;
                end
            end

            ST_MID:
            begin
                if (zp_reg && pad_reg != '0)
                begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO;
                    pad_next  = pad_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end

            ST_ZERO:
            begin
                if (zcnt_reg != '0)
                begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO;
                    zcnt_next = zcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                // Pad left over here is the trailing run of a left-justified field
                emit      = 1'b1;
                emit_char = digit_char(ram_rdata, lower_reg);
                if (dig_idx_reg == '0)
                begin
                    emit_last  = (pad_reg == '0);
                    state_next = (pad_reg == '0) ? ST_IDLE : ST_TRAIL;
                end
                else
                begin
                    dig_idx_next = dig_idx_reg - 1'b1;
                end
            end

            ST_TRAIL:
            begin
                emit      = 1'b1;
                emit_char = CH_SPACE;
                pad_next  = pad_reg - 1'b1;
                if (pad_reg == FIELD_W'(1))
                begin
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg   <= emit_char;
        last_reg       <= emit_last;
        bad_reg        <= emit_bad;
        width_reg      <= width_next;
        prec_reg       <= prec_next;
        lead_reg       <= lead_next;
        zp_reg         <= zp_next;
        lower_reg      <= lower_next;
        hex_reg        <= hex_next;
        has_sign_reg   <= has_sign_next;
        sign_reg       <= sign_next;
        pfx_len_reg    <= pfx_len_next;
        radix_hold_reg <= radix_hold_next;
        ndig_reg       <= ndig_next;
        dig_idx_reg    <= dig_idx_next;
        pad_reg        <= pad_next;
        zcnt_reg       <= zcnt_next;
        pfx_cnt_reg    <= pfx_cnt_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;
    assign bad_radix = bad_reg;

`ifndef SYNTHESIS
    // A transaction ends with its last character on the output
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last_char))
        else $error("busy dropped without a final character");

    // Error results are always single and final
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && bad_radix) |-> (last_char && out_char == CH_NUL))
        else $error("bad radix result malformed");

    // Text only comes out of a running conversion
    a_text_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !bad_radix) |-> $past(busy))
        else $error("character emitted outside a conversion");

    // Divider completes only while digits are being extracted
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside extraction");
`endif

endmodule
